// ===== rtl/bts_pkg.sv =====
package bts_pkg;

  localparam int KIND_W = 2;
  localparam int TSEL_W = 2;
  localparam int SLOT_W = 3;
  localparam int VAL_W  = 16;

  localparam int TUNES_DEFAULT          = 4;
  localparam int NOTES_PER_TUNE_DEFAULT = 8;

  localparam logic [VAL_W-1:0] UNIT_TICKS_RESET = 16'd1000;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_START = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_PLAY  = 2'd1,
    PH_PAUSE = 2'd2
  } phase_t;

  typedef struct packed {
    logic [VAL_W-1:0] gap;
    logic [VAL_W-1:0] dur;
    logic [VAL_W-1:0] per;
  } note_t;

endpackage

// ===== rtl/bts_note_mem.sv =====
module bts_note_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  bts_pkg::note_t wdata,
  input  logic [AW-1:0] raddr,
  output bts_pkg::note_t rdata
);
  import bts_pkg::*;

  note_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-through so a load to the note being read is seen next cycle
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/buzzer_tune_sequencer_top.sv =====
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+---------------------------------------------
// input    | in        | in_valid / in_stall    | kind tune_select slot tone_period tone_length
//          |           |                        | gap_length final_slot
// result   | out       | out_valid / out_stall  | tone_out phase note_now tune_done
// config   | in        | cfg_valid / cfg_ready  | unit_ticks
//
// one item per cycle while the result is not stalled: each transfer is worked into the result register,
// the note of the current tune is read ahead from the note memory at the next-state address.
// rst is synchronous; after reset the block waits with every tune one note long.
// in_stall follows out_stall only while a result is held; cfg_ready is always high.
module buzzer_tune_sequencer_top #(
  parameter int TUNES          = bts_pkg::TUNES_DEFAULT,
  parameter int NOTES_PER_TUNE = bts_pkg::NOTES_PER_TUNE_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bts_pkg::KIND_W-1:0] kind,
  input  logic [bts_pkg::TSEL_W-1:0] tune_select,
  input  logic [bts_pkg::SLOT_W-1:0] slot,
  input  logic [bts_pkg::VAL_W-1:0]  tone_period,
  input  logic [bts_pkg::VAL_W-1:0]  tone_length,
  input  logic [bts_pkg::VAL_W-1:0]  gap_length,
  input  logic                       final_slot,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       tone_out,
  output logic [1:0]                 phase,
  output logic [bts_pkg::SLOT_W-1:0] note_now,
  output logic                       tune_done,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bts_pkg::VAL_W-1:0]  unit_ticks
);
  import bts_pkg::*;

  localparam int DEPTH = TUNES * NOTES_PER_TUNE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TIW   = (TUNES > 1) ? $clog2(TUNES) : 1;

  logic [VAL_W-1:0]  unit_ticks_reg;
  phase_t            phase_reg, phase_next;
  logic [TSEL_W-1:0] active_tune, active_tune_next;
  logic [SLOT_W-1:0] note_pos, note_pos_next;
  logic [VAL_W-1:0]  tone_count, tone_count_next;
  logic [VAL_W-1:0]  unit_prescale, unit_prescale_next;
  logic [VAL_W-1:0]  unit_count, unit_count_next;
  logic [SLOT_W-1:0] tune_last [TUNES];

  logic              in_accept;
  logic              load_ok, start_ok;
  note_t             cur_note, load_note;
  logic [AW-1:0]     waddr, raddr;
  logic [VAL_W-1:0]  units, ut;
  logic              unit_wrap, ends, advance;
  logic              tone_c, done_c;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign load_ok  = (kind == KIND_LOAD) && (32'(tune_select) < TUNES)
                    && (32'(slot) < NOTES_PER_TUNE);
  assign start_ok = (kind == KIND_START) && (32'(tune_select) < TUNES);

  assign load_note = '{gap: gap_length, dur: tone_length, per: tone_period};
  assign waddr = AW'(32'(tune_select) * NOTES_PER_TUNE + 32'(slot));
  assign raddr = AW'(32'(active_tune_next) * NOTES_PER_TUNE + 32'(note_pos_next));

  bts_note_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_note_mem (
    .clk   (clk),
    .we    (in_accept && load_ok),
    .waddr (waddr),
    .wdata (load_note),
    .raddr (raddr),
    .rdata (cur_note)
  );

  // timing of the current note
  assign ut        = (unit_ticks_reg == '0) ? VAL_W'(1) : unit_ticks_reg;
  assign units     = (phase_reg == PH_PLAY) ? cur_note.dur : cur_note.gap;
  assign unit_wrap = ({1'b0, unit_prescale} + (VAL_W+1)'(1)) >= {1'b0, ut};
  assign ends      = unit_wrap && (unit_count >= units);
  assign advance   = (note_pos < tune_last[TIW'(active_tune)])
                     && ((32'(note_pos) + 1) < NOTES_PER_TUNE);

  // next state
  always_comb begin
    phase_next         = phase_reg;
    active_tune_next   = active_tune;
    note_pos_next      = note_pos;
    tone_count_next    = tone_count;
    unit_prescale_next = unit_prescale;
    unit_count_next    = unit_count;
    if (in_accept) begin
      unique case (kind)
        KIND_TICK: begin
          if (phase_reg != PH_WAIT) begin
            if (phase_reg == PH_PLAY) begin
              tone_count_next = (tone_count >= cur_note.per) ? '0 : tone_count + 1'b1;
            end
            if (unit_wrap) begin
              unit_prescale_next = '0;
              if (!ends) begin
                unit_count_next = unit_count + 1'b1;
              end
            end else begin
              unit_prescale_next = unit_prescale + 1'b1;
            end
            if (ends) begin
              tone_count_next    = '0;
              unit_prescale_next = '0;
              unit_count_next    = '0;
              if (phase_reg == PH_PLAY) begin
                phase_next = PH_PAUSE;
              end else if (advance) begin
                note_pos_next = note_pos + 1'b1;
                phase_next    = PH_PLAY;
              end else begin
                phase_next = PH_WAIT;
              end
            end
          end
        end
        KIND_START: begin
          if (start_ok) begin
            active_tune_next   = tune_select;
            note_pos_next      = '0;
            phase_next         = PH_PLAY;
            tone_count_next    = '0;
            unit_prescale_next = '0;
            unit_count_next    = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result of the item
  always_comb begin
    tone_c = 1'b0;
    done_c = 1'b0;
    if (kind == KIND_TICK) begin
      tone_c = (phase_reg == PH_PLAY) && (tone_count < (cur_note.per >> 1));
      done_c = (phase_reg == PH_PAUSE) && ends && !advance;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks_reg <= UNIT_TICKS_RESET;
      phase_reg      <= PH_WAIT;
      active_tune    <= '0;
      note_pos       <= '0;
      tone_count     <= '0;
      unit_prescale  <= '0;
      unit_count     <= '0;
      for (int i = 0; i < TUNES; i++) begin
        tune_last[i] <= '0;
      end
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unit_ticks_reg <= unit_ticks;
      end
      phase_reg     <= phase_next;
      active_tune   <= active_tune_next;
      note_pos      <= note_pos_next;
      tone_count    <= tone_count_next;
      unit_prescale <= unit_prescale_next;
      unit_count    <= unit_count_next;
      if (in_accept && load_ok && final_slot) begin
        tune_last[TIW'(tune_select)] <= slot;
      end
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // tick reports the cycle before it advances, other items report the new state
  always_ff @(posedge clk) begin
    if (in_accept) begin
      tone_out  <= tone_c;
      tune_done <= done_c;
      phase     <= (kind == KIND_TICK) ? phase_reg : phase_next;
      note_now  <= (kind == KIND_TICK) ? note_pos : note_pos_next;
    end
  end

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bts_pkg::*;

  localparam int TUNES_N = TUNES_DEFAULT;
  localparam int NOTES = NOTES_PER_TUNE_DEFAULT;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 150;
  localparam int MAX_REPORTS = 10;
  localparam int TICK_CAP = 150;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [TSEL_W-1:0] tsel;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  per;
    logic [VAL_W-1:0]  dur;
    logic [VAL_W-1:0]  gap;
    logic              fin;
  } tune_item_t;

  typedef struct {
    logic              tone;
    logic [1:0]        ph;
    logic [SLOT_W-1:0] note;
    logic              done;
  } buzz_out_t;

  class tune_scoreboard;
    logic [VAL_W-1:0]  ticks_per_unit;
    phase_t            ph;
    logic [TSEL_W-1:0] cur_tune;
    logic [SLOT_W-1:0] cur_note;
    logic [VAL_W-1:0]  tone_cnt;
    logic [VAL_W-1:0]  prescale;
    logic [VAL_W-1:0]  unit_cnt;
    note_t             notes [TUNES_N][NOTES];
    logic [SLOT_W-1:0] last_note [TUNES_N];
    buzz_out_t         expected_q [$];
    int                mismatches;
    int                checked;
    int                done_pulses;

    function new();
      ticks_per_unit = UNIT_TICKS_RESET;
      cur_tune = '0;
      cur_note = '0;
      enter_phase(PH_WAIT);
      foreach (notes[t, s]) notes[t][s] = '0;
      foreach (last_note[t]) last_note[t] = '0;
      mismatches = 0;
      checked = 0;
      done_pulses = 0;
    endfunction

    function void enter_phase(phase_t p);
      ph = p;
      tone_cnt = '0;
      prescale = '0;
      unit_cnt = '0;
    endfunction

    function void set_unit_ticks(logic [VAL_W-1:0] v);
      ticks_per_unit = v;
    endfunction

    function void note_item(tune_item_t it);
      buzz_out_t        r;
      note_t            cur;
      logic [VAL_W-1:0] units;
      int               unit_len;
      bit               ends;
      r.tone = 1'b0;
      r.done = 1'b0;
      r.ph = ph;
      r.note = cur_note;
      ends = 0;
      if (it.kind == KIND_TICK) begin
        if (ph != PH_WAIT) begin
          cur = notes[cur_tune][cur_note];
          units = (ph == PH_PLAY) ? cur.dur : cur.gap;
          // a zero prescaler counts as one
          unit_len = (ticks_per_unit == 0) ? 1 : int'(ticks_per_unit);
          if (ph == PH_PLAY) begin
            r.tone = (tone_cnt < (cur.per >> 1));
            tone_cnt = (tone_cnt >= cur.per) ? '0 : tone_cnt + 1'b1;
          end
          if (int'(prescale) + 1 >= unit_len) begin
            prescale = '0;
            if (unit_cnt >= units) ends = 1;
            else unit_cnt = unit_cnt + 1'b1;
          end else begin
            prescale = prescale + 1'b1;
          end
          if (ends) begin
            if (ph == PH_PLAY) begin
              enter_phase(PH_PAUSE);
            end else if (cur_note < last_note[cur_tune] && int'(cur_note) + 1 < NOTES) begin
              cur_note = cur_note + 1'b1;
              enter_phase(PH_PLAY);
            end else begin
              enter_phase(PH_WAIT);
              r.done = 1'b1;
              done_pulses++;
            end
          end
        end
      end else begin
        if (it.kind == KIND_LOAD) begin
          notes[it.tsel][it.slot] = {it.gap, it.dur, it.per};
          if (it.fin) last_note[it.tsel] = it.slot;
        end else if (it.kind == KIND_START) begin
          cur_tune = it.tsel;
          cur_note = '0;
          enter_phase(PH_PLAY);
        end
        r.ph = ph;
        r.note = cur_note;
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(buzz_out_t got);
      buzz_out_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: tone=%0b phase=%0d note=%0d done=%0b",
                   got.tone, got.ph, got.note, got.done);
        return;
      end
      want = expected_q.pop_front();
      if (got.tone !== want.tone || got.ph !== want.ph || got.note !== want.note ||
          got.done !== want.done) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d: expected tone=%0b phase=%0d note=%0d done=%0b, got tone=%0b phase=%0d note=%0d done=%0b",
                   checked, want.tone, want.ph, want.note, want.done,
                   got.tone, got.ph, got.note, got.done);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  tune_item_t        drive_item;
  logic              out_valid;
  logic              out_stall;
  logic              tone_out;
  logic [1:0]        phase;
  logic [SLOT_W-1:0] note_now;
  logic              tune_done;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [VAL_W-1:0]  unit_ticks;

  tune_scoreboard sb = new();

  bit               loaded [TUNES_N][NOTES];
  logic [VAL_W-1:0] cur_ticks = UNIT_TICKS_RESET;
  int               counted_items = 0;
  int               accepted = 0;
  int               input_held = 0;
  int               long_holds = 0;
  bit               send_calm = 0;
  bit               recv_calm = 0;
  bit               rush = 0;
  bit               hold_req = 0;

  buzzer_tune_sequencer_top DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (drive_item.kind),
    .tune_select(drive_item.tsel),
    .slot       (drive_item.slot),
    .tone_period(drive_item.per),
    .tone_length(drive_item.dur),
    .gap_length (drive_item.gap),
    .final_slot (drive_item.fin),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tone_out   (tone_out),
    .phase      (phase),
    .note_now   (note_now),
    .tune_done  (tune_done),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .unit_ticks (unit_ticks)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    buzz_out_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.tone = tone_out;
        got.ph = phase;
        got.note = note_now;
        got.done = tune_done;
        sb.check_result(got);
      end
      if (in_valid && !in_stall) begin
        sb.note_item(drive_item);
        accepted++;
      end
      if (in_valid && in_stall) input_held++;
    end
  end

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [VAL_W-1:0] rand_val(int max_small);
    if ($urandom_range(0, 99) < 85) return VAL_W'($urandom_range(0, max_small));
    return VAL_W'($urandom);
  endfunction

  // receiver: random stall bursts, quiet stretches, and one long hold-off on request
  initial begin
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1'b1;
        long_holds++;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
        if (!recv_calm && $urandom_range(0, 99) < 20) burst = idle_len();
      end
    end
  end

  task automatic send_item(tune_item_t it);
    int gap;
    gap = 0;
    if (!rush && !send_calm && $urandom_range(0, 99) < 30) gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    drive_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.kind != KIND_SPARE) counted_items++;
    if ($urandom_range(0, 149) == 0) send_calm = !send_calm;
  endtask

  task automatic send_plain(logic [KIND_W-1:0] k);
    tune_item_t it;
    it = '{k, TSEL_W'($urandom), SLOT_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
           VAL_W'($urandom), 1'($urandom)};
    send_item(it);
  endtask

  task automatic tick_now();
    send_plain(KIND_TICK);
  endtask

  // a final mark only lands where every lower slot of the tune holds a note,
  // so playback never reaches a slot that was never loaded
  task automatic load_note(int t, int s, logic [VAL_W-1:0] per, logic [VAL_W-1:0] dur,
                           logic [VAL_W-1:0] gap, bit fin);
    tune_item_t it;
    int k;
    for (k = 0; k < s; k++) if (!loaded[t][k]) fin = 0;
    loaded[t][s] = 1;
    it = '{KIND_LOAD, TSEL_W'(t), SLOT_W'(s), per, dur, gap, fin};
    send_item(it);
  endtask

  task automatic start_tune(int t);
    tune_item_t it;
    if (loaded[t][0]) begin
      it = '{KIND_START, TSEL_W'(t), SLOT_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
             VAL_W'($urandom), 1'($urandom)};
      send_item(it);
    end else begin
      tick_now();
    end
  endtask

  task automatic noise_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      load_note($urandom_range(0, TUNES_N-1), $urandom_range(0, NOTES-1), rand_val(24),
                rand_val(2), rand_val(2), 1'($urandom));
    else if (pick < 60) start_tune($urandom_range(0, TUNES_N-1));
    else if (pick < 70) send_plain(KIND_SPARE);
    else tick_now();
  endtask

  // program a short tune, start it and mostly let it run to its done pulse
  task automatic play_episode();
    int t, n, s, ticks, span, unit_len;
    logic [VAL_W-1:0] per, dur, gap;
    t = $urandom_range(0, TUNES_N-1);
    n = ($urandom_range(0, 3) == 0) ? NOTES-1 : $urandom_range(0, NOTES-1);
    unit_len = (cur_ticks == 0) ? 1 : int'(cur_ticks);
    span = 0;
    for (s = 0; s <= n; s++) begin
      per = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom_range(0, 1))
                                        : VAL_W'($urandom_range(2, 24));
      dur = VAL_W'($urandom_range(0, 2));
      gap = VAL_W'($urandom_range(0, 2));
      if ($urandom_range(0, 19) == 0) noise_item();
      load_note(t, s, per, dur, gap, (s == n) || ($urandom_range(0, 7) == 0));
      span += (int'(dur) + int'(gap) + 2) * unit_len;
    end
    start_tune(t);
    ticks = ($urandom_range(0, 3) != 0) ? span + 3 : $urandom_range(1, span + 3);
    if (ticks > TICK_CAP) ticks = TICK_CAP;
    repeat (ticks) begin
      if ($urandom_range(0, 29) == 0) noise_item();
      else tick_now();
    end
  endtask

  // the block must be quiet before the prescaler changes
  task automatic write_unit_ticks(logic [VAL_W-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    unit_ticks <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_unit_ticks(v);
    cur_ticks = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [VAL_W-1:0] settings [7];
    int idx, budget, start_count, waited, leftover;
    rst = 1'b1;
    in_valid = 1'b0;
    drive_item = '{'0, '0, '0, '0, '0, '0, 1'b0};
    cfg_valid = 1'b0;
    unit_ticks = UNIT_TICKS_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle block, spare code, a note under the reset prescaler, all-ones slot
    tick_now();
    send_plain(KIND_SPARE);
    load_note(0, 0, 16'd5, 16'd0, 16'd0, 1'b0);
    start_tune(0);
    repeat (3) tick_now();
    load_note(3, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);

    // two silent notes to the done pulse; clearing a final mark changes nothing
    write_unit_ticks(16'd1);
    load_note(1, 0, 16'd1, 16'd0, 16'd0, 1'b0);
    load_note(1, 1, 16'd0, 16'd1, 16'd0, 1'b1);
    load_note(1, 1, 16'd0, 16'd1, 16'd0, 1'b0);
    start_tune(1);
    repeat (6) tick_now();

    // final mark moved below the playing note ends the tune after its pause
    load_note(2, 0, 16'd3, 16'd1, 16'd0, 1'b0);
    load_note(2, 1, 16'd4, 16'd0, 16'd0, 1'b1);
    start_tune(2);
    repeat (3) tick_now();
    load_note(2, 0, 16'd3, 16'd1, 16'd0, 1'b1);
    repeat (3) tick_now();

    settings = '{16'd2, 16'd0, 16'hFFFF, 16'd1, 16'd3, VAL_W'($urandom_range(1, 4)), 16'd1};
    for (idx = 0; idx < 7; idx++) begin
      write_unit_ticks(settings[idx]);
      budget = (settings[idx] == 16'hFFFF) ? 60 : 200;
      start_count = counted_items;
      if (idx == 3) begin
        // back-to-back transfers into a long receiver hold-off
        rush = 1;
        hold_req = 1;
        play_episode();
        rush = 0;
      end
      while (counted_items - start_count < budget) play_episode();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (sb.expected_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    leftover = sb.expected_q.size();
    $display("%0d transfers in (%0d cycles held off), %0d results checked, %0d tunes ended",
             accepted, input_held, sb.checked, sb.done_pulses);
    $display("prescaler at reset, 1, 2, 0, 1, 3, max and random; %0d long hold-offs, %0d mismatches, %0d missing",
             long_holds, sb.mismatches, leftover);
    if (sb.mismatches == 0 && leftover == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
